@@ hw/rtl/rs16_pkg.sv @@
// ----------------------------------------------------------------------------
// rs16_pkg
// Shared types, codes and filter coefficients of the 16 kHz resampler.
// ----------------------------------------------------------------------------
package rs16_pkg;

    localparam int DEF_FILTER_ORDER = 7;
    localparam int DEF_QUEUE_DEPTH  = 2;

    // rate_mode codes
    localparam logic [2:0] MODE_8K  = 3'd0;
    localparam logic [2:0] MODE_12K = 3'd1;
    localparam logic [2:0] MODE_16K = 3'd2;
    localparam logic [2:0] MODE_24K = 3'd3;
    localparam logic [2:0] MODE_48K = 3'd4;

    // coefficient set codes
    localparam logic [1:0] CS_48K = 2'd0;
    localparam logic [1:0] CS_12K = 2'd1;
    localparam logic [1:0] CS_8K  = 2'd2;

    typedef logic signed [31:0] coef_t;

    // one classified item handed from front to back
    typedef struct packed {
        logic               pass;
        logic               decim;
        logic [1:0]         cset;
        logic [1:0]         up_m1;
        logic signed [15:0] x;
    } cmd_t;

    // Q5.26 from design values given in units of 1e-9
    localparam longint CqScale = 64'sd67108864;
    localparam longint CqHalf  = 64'sd500000000;
    localparam longint CqDen   = 64'sd1000000000;

    localparam coef_t B0_48K = coef_t'((64'sd4523418 * CqScale + CqHalf) / CqDen);
    localparam coef_t B0_12K = coef_t'((64'sd2033597 * CqScale + CqHalf) / CqDen);
    localparam coef_t B0_8K  = coef_t'((64'sd20109186 * CqScale + CqHalf) / CqDen);

    localparam coef_t B_48K [7] = '{
        coef_t'((64'sd5873358 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd12980855 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd14531340 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd14531340 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd12980855 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd5873358 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd4523418 * CqScale + CqHalf) / CqDen)
    };
    localparam coef_t A_48K [7] = '{
        coef_t'((-64'sd3878718598 * CqScale - CqHalf) / CqDen),
        coef_t'((64'sd7748834257 * CqScale + CqHalf) / CqDen),
        coef_t'((-64'sd9653651700 * CqScale - CqHalf) / CqDen),
        coef_t'((64'sd8007342727 * CqScale + CqHalf) / CqDen),
        coef_t'((-64'sd4379450179 * CqScale - CqHalf) / CqDen),
        coef_t'((64'sd1463182112 * CqScale + CqHalf) / CqDen),
        coef_t'((-64'sd231720678 * CqScale - CqHalf) / CqDen)
    };
    localparam coef_t B_12K [7] = '{
        coef_t'((-64'sd1017101 * CqScale - CqHalf) / CqDen),
        coef_t'((64'sd3673127 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd1009165 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd1009165 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd3673127 * CqScale + CqHalf) / CqDen),
        coef_t'((-64'sd1017101 * CqScale - CqHalf) / CqDen),
        coef_t'((64'sd2033597 * CqScale + CqHalf) / CqDen)
    };
    localparam coef_t A_12K [7] = '{
        coef_t'((-64'sd4930414412 * CqScale - CqHalf) / CqDen),
        coef_t'((64'sd11291643097 * CqScale + CqHalf) / CqDen),
        coef_t'((-64'sd15322037344 * CqScale - CqHalf) / CqDen),
        coef_t'((64'sd13216403931 * CqScale + CqHalf) / CqDen),
        coef_t'((-64'sd7220409220 * CqScale - CqHalf) / CqDen),
        coef_t'((64'sd2310550143 * CqScale + CqHalf) / CqDen),
        coef_t'((-64'sd334338619 * CqScale - CqHalf) / CqDen)
    };
    localparam coef_t B_8K [7] = '{
        coef_t'((64'sd81670121 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd180401599 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd259391052 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd259391052 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd180401599 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd81670121 * CqScale + CqHalf) / CqDen),
        coef_t'((64'sd20109186 * CqScale + CqHalf) / CqDen)
    };
    localparam coef_t A_8K [7] = '{
        coef_t'((-64'sd1393651934 * CqScale - CqHalf) / CqDen),
        coef_t'((64'sd2609789873 * CqScale + CqHalf) / CqDen),
        coef_t'((-64'sd2403541969 * CqScale - CqHalf) / CqDen),
        coef_t'((64'sd2056814957 * CqScale + CqHalf) / CqDen),
        coef_t'((-64'sd1148908575 * CqScale - CqHalf) / CqDen),
        coef_t'((64'sd473001414 * CqScale + CqHalf) / CqDen),
        coef_t'((-64'sd110359852 * CqScale - CqHalf) / CqDen)
    };

    function automatic coef_t coef_b0(input logic [1:0] cs);
        coef_t r;
        unique case (cs)
            CS_48K:  r = B0_48K;
            CS_12K:  r = B0_12K;
            CS_8K:   r = B0_8K;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic coef_t coef_b(input logic [1:0] cs, input logic [2:0] i);
        coef_t r;
        unique case (cs)
            CS_48K:  r = B_48K[i];
            CS_12K:  r = B_12K[i];
            CS_8K:   r = B_8K[i];
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic coef_t coef_a(input logic [1:0] cs, input logic [2:0] i);
        coef_t r;
        unique case (cs)
            CS_48K:  r = A_48K[i];
            CS_12K:  r = A_12K[i];
            CS_8K:   r = A_8K[i];
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/rs16_front.sv @@
// ----------------------------------------------------------------------------
// rs16_front
// Accepts input items, decodes the rate, downmixes, scales and saturates.
// ----------------------------------------------------------------------------
module rs16_front
    import rs16_pkg::*;
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  logic [2:0]  rate_mode,
    input  logic        stereo,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic signed [15:0] left_w;
    logic signed [15:0] right_w;
    logic signed [16:0] sum_w;
    logic signed [19:0] scaled_w;
    logic signed [19:0] half_w;
    logic signed [19:0] mix_w;
    logic [1:0]         sh_w;
    logic               mode_ok_w;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)
            r = 16'sh7FFF;
        else if (v < -20'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    assign left_w  = $signed(s_axis_tdata[15:0]);
    assign right_w = $signed(s_axis_tdata[31:16]);
    assign sum_w   = 17'(left_w) + 17'(right_w);

    always_comb
    begin
        mode_ok_w     = 1'b1;
        q_cmd.pass    = 1'b0;
        q_cmd.decim   = 1'b0;
        q_cmd.cset    = CS_48K;
        q_cmd.up_m1   = 2'd0;
        q_cmd.x       = sat16(mix_w);
        sh_w          = 2'd0;
        unique case (rate_mode)
            MODE_8K:
            begin
                q_cmd.cset  = CS_8K;
                q_cmd.up_m1 = 2'd1;
                sh_w        = 2'd1;
            end
            MODE_12K:
            begin
                q_cmd.cset  = CS_12K;
                q_cmd.decim = 1'b1;
                q_cmd.up_m1 = 2'd3;
                sh_w        = 2'd2;
            end
            MODE_16K:
            begin
                q_cmd.pass = 1'b1;
            end
            MODE_24K:
            begin
                q_cmd.decim = 1'b1;
                q_cmd.up_m1 = 2'd1;
                sh_w        = 2'd1;
            end
            MODE_48K:
            begin
                q_cmd.decim = 1'b1;
            end
            default:
            begin
                mode_ok_w = 1'b0;
            end
        endcase
    end

    // stereo: up*(l+r)/2, ties to even
    always_comb
    begin
        if (stereo)
        begin
            scaled_w = 20'(sum_w) <<< sh_w;
            half_w   = scaled_w >>> 1;
            if (scaled_w[0] && half_w[0])
                mix_w = half_w + 20'sd1;
            else
                mix_w = half_w;
        end
        else
        begin
            scaled_w = 20'(left_w) <<< sh_w;
            half_w   = scaled_w;
            mix_w    = scaled_w;
        end
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full && mode_ok_w;

endmodule

@@ hw/rtl/rs16_queue.sv @@
// ----------------------------------------------------------------------------
// rs16_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module rs16_queue
    import rs16_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == NW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ hw/rtl/rs16_back.sv @@
// ----------------------------------------------------------------------------
// rs16_back
// Filter sequencer: zero stuffing, transposed DF-II IIR one delay cell at a
// time, decimation and output register.
// ----------------------------------------------------------------------------
module rs16_back
    import rs16_pkg::*;
#(
    parameter int FILTER_ORDER = DEF_FILTER_ORDER
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_head,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_sample
    output logic        m_axis_tlast    // last_of_run
);

    localparam int CW = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_Y0   = 3'd1;
    localparam logic [2:0] ST_Y1   = 3'd2;
    localparam logic [2:0] ST_M0   = 3'd3;
    localparam logic [2:0] ST_M1   = 3'd4;
    localparam logic [2:0] ST_M2   = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic [1:0]         k_reg;
    logic [1:0]         k_next;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      j_next;
    logic [1:0]         phase_reg;
    logic [1:0]         phase_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] out_sample_reg;
    logic signed [15:0] out_sample_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic signed [47:0] mem_reg [FILTER_ORDER];
    logic signed [47:0] y_reg;
    logic signed [47:0] px_reg;
    logic signed [56:0] plo_reg;
    logic signed [55:0] phi_reg;
    logic signed [54:0] ya_reg;
    logic signed [46:0] xb_reg;

    logic signed [15:0] x_cur;
    coef_t              cb_w;
    coef_t              ca_w;
    logic signed [24:0] y_lo;
    logic signed [23:0] y_hi;
    logic signed [48:0] px_rnd;
    logic signed [46:0] xb_w;
    logic signed [57:0] t_w;
    logic signed [56:0] m_w;
    logic [CW:0]        jn_w;
    logic signed [47:0] nxt_w;
    logic signed [47:0] mem_wdata;
    logic               mem_we;
    logic signed [48:0] rnd_w;
    logic signed [15:0] y_out_w;
    logic               j_last;
    logic [1:0]         ph_eff;
    logic [1:0]         ph_inc;
    logic [1:0]         rem_w;
    logic [1:0]         dist_w;
    logic               keep_w;
    logic               last_w;
    logic               out_free;

    function automatic logic signed [47:0] sat48(input logic signed [57:0] v);
        logic signed [47:0] r;
        if (v > 58'sh7FFFFFFFFFFF)
            r = 48'sh7FFFFFFFFFFF;
        else if (v < -58'sh800000000000)
            r = 48'sh800000000000;
        else
            r = v[47:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
        logic signed [15:0] r;
        if (v > 25'sd32767)
            r = 16'sh7FFF;
        else if (v < -25'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // datapath
    assign x_cur   = (k_reg == 2'd0) ? cmd_reg.x : 16'sd0;
    assign cb_w    = (state_reg == ST_Y0) ? coef_b0(cmd_reg.cset)
                                          : coef_b(cmd_reg.cset, 3'(j_reg));
    assign ca_w    = coef_a(cmd_reg.cset, 3'(j_reg));
    assign y_lo    = $signed({1'b0, y_reg[23:0]});
    assign y_hi    = $signed(y_reg[47:24]);
    assign px_rnd  = 49'(px_reg) + 49'sd2;
    assign xb_w    = px_rnd[48:2];
    assign t_w     = 58'(plo_reg) + 58'sd33554432;
    assign m_w     = 57'(phi_reg) + 57'($signed(t_w[57:24]));
    assign jn_w    = {1'b0, j_reg} + 1'b1;
    assign nxt_w   = (jn_w < (CW+1)'(FILTER_ORDER)) ? mem_reg[jn_w[CW-1:0]] : 48'sd0;
    assign mem_wdata = sat48(58'(nxt_w) + 58'(xb_reg) - 58'(ya_reg));
    assign rnd_w   = 49'(y_reg) + 49'sd8388608;
    assign y_out_w = sat16($signed(rnd_w[48:24]));
    assign j_last  = (j_reg == CW'(FILTER_ORDER - 1));

    // decimation: keep on phase 0; last when no later kept step in this item
    assign ph_eff   = (phase_reg == 2'd3) ? 2'd0 : phase_reg;
    assign ph_inc   = (ph_eff == 2'd2) ? 2'd0 : ph_eff + 2'd1;
    assign rem_w    = cmd_reg.up_m1 - k_reg;
    assign dist_w   = (ph_inc == 2'd0) ? 2'd0 : 2'd3 - ph_inc;
    assign keep_w   = !cmd_reg.decim || (ph_eff == 2'd0);
    assign last_w   = cmd_reg.decim ? (dist_w >= rem_w) : (rem_w == 2'd0);
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        phase_next      = phase_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    k_next     = 2'd0;
                    state_next = q_head.pass ? ST_OUT : ST_Y0;
                end
            end
            ST_Y0:
            begin
                state_next = ST_Y1;
            end
            ST_Y1:
            begin
                j_next     = '0;
                state_next = ST_M0;
            end
            ST_M0:
            begin
                state_next = ST_M1;
            end
            ST_M1:
            begin
                state_next = ST_M2;
            end
            ST_M2:
            begin
                mem_we = 1'b1;
                if (j_last)
                    state_next = ST_OUT;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_M0;
                end
            end
            ST_OUT:
            begin
                if (cmd_reg.pass)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_sample_next = cmd_reg.x;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (!keep_w || out_free)
                begin
                    if (keep_w)
                    begin
                        out_valid_next  = 1'b1;
                        out_sample_next = y_out_w;
                        out_last_next   = last_w;
                    end
                    if (cmd_reg.decim)
                        phase_next = ph_inc;
                    if (k_reg == cmd_reg.up_m1)
                        state_next = ST_IDLE;
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_Y0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= 2'd0;
            j_reg         <= '0;
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FILTER_ORDER; i++)
                mem_reg[i] <= 48'sd0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (mem_we)
                mem_reg[j_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
        if (state_reg == ST_Y0 || state_reg == ST_M0)
            px_reg <= x_cur * cb_w;
        if (state_reg == ST_Y1)
            y_reg <= sat48(58'(xb_w) + 58'(mem_reg[0]));
        if (state_reg == ST_M0)
        begin
            plo_reg <= ca_w * y_lo;
            phi_reg <= ca_w * y_hi;
        end
        if (state_reg == ST_M1)
        begin
            ya_reg <= m_w[56:2];
            xb_reg <= xb_w;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tlast  = out_last_reg;

    a_m1_after_m0: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_M1 |-> $past(state_reg) == ST_M0)
        else $error("cell update skipped its multiply stage");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && q_valid) |=> (state_reg == ST_Y0 || state_reg == ST_OUT))
        else $error("popped command not started");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("decimation phase out of range");

    a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CW+1)'(j_reg) < (CW+1)'(FILTER_ORDER))
        else $error("cell index beyond filter order");

endmodule

@@ hw/rtl/resample_to_16k_elliptic_iir.sv @@
// ----------------------------------------------------------------------------
// resample_to_16k_elliptic_iir
// Resampler to 16 kHz: downmix, zero stuffing, 7th-order elliptic IIR,
// keep one of three at the 48 kHz intermediate rate.
//
// channel  dir  handshake        payload
// s_axis   in   tvalid/tready    tdata[15:0] left_sample, [31:16] right_sample
// m_axis   out  tvalid/tready    tdata[15:0] out_sample, tlast last_of_run
// cfg      in   cfg_valid/ready  cfg_index (0 rate_mode, 1 stereo), cfg_data
//
// Filtered items walk the back sequencer states Y0, Y1, then M0, M1, M2 for
// each delay cell, then OUT, once per zero-stuffed step; 16 kHz items go
// straight to OUT. One shared multiplier set walks the delay cells.
// Reset clears filter state, phase, queue and output valid at once.
// Input stalls only when the command queue is full; the back stalls on a
// taken sample while the output register is held.
// ----------------------------------------------------------------------------
module resample_to_16k_elliptic_iir
    import rs16_pkg::*;
#(
    parameter int FILTER_ORDER = DEF_FILTER_ORDER,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_sample
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data
);

    localparam logic [1:0] CFG_RATE_MODE = 2'd0;
    localparam logic [1:0] CFG_STEREO    = 2'd1;

    logic [2:0] rate_mode_reg;
    logic       stereo_reg;
    logic       q_full;
    logic       q_push;
    cmd_t       q_cmd;
    logic       q_pop;
    logic       q_valid;
    cmd_t       q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_mode_reg <= MODE_48K;
            stereo_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_RATE_MODE)
                rate_mode_reg <= cfg_data;
            if (cfg_index == CFG_STEREO)
                stereo_reg <= cfg_data[0];
        end
    end

    rs16_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .rate_mode     (rate_mode_reg),
        .stereo        (stereo_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    rs16_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    rs16_back #(
        .FILTER_ORDER (FILTER_ORDER)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ tb/resample_to_16k_elliptic_iir_test.sv @@
// ----------------------------------------------------------------------------
// resample_to_16k_elliptic_iir_test
// Self-checking bench for the 16 kHz resampler. A bit-true software copy of
// the downmix, the zero stuffing, the elliptic IIR and the keep-one-of-three
// phase predicts every output item. Stimulus covers each rate, mono and
// stereo, ignored rate codes, full-scale and random audio, under several
// patterns of source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module resample_to_16k_elliptic_iir_test;
    import rs16_pkg::*;

    localparam logic [1:0] REG_RATE_MODE = 2'd0;
    localparam logic [1:0] REG_STEREO    = 2'd1;
    localparam logic [1:0] REG_SPARE     = 2'd3;

    localparam int     TAPS          = 7;
    localparam int     SETTLE_CYCLES = 400;
    localparam int     ITEM_TARGET   = 1350;
    localparam longint MAX48         = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint MIN48         = -MAX48 - 64'sd1;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } pcm16_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [2:0]  cfg_data = '0;

    logic [31:0] pending_frames [$];
    pcm16_t      expected_pcm [$];
    pcm16_t      want;

    // filter copy
    longint      tap_b0 [3];
    longint      tap_b [3][TAPS];
    longint      tap_a [3][TAPS];
    longint      dly [TAPS];
    logic [1:0]  phase;
    logic [2:0]  rate_cfg;
    logic        stereo_cfg;

    bit          in_taken;
    int          errors = 0;
    int          filtered_items = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    resample_to_16k_elliptic_iir dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // design value in units of 1e-9 to Q5.26, half away from zero
    function automatic longint q526(input longint n);
        longint half;
        half = (n >= 0) ? 64'sd500000000 : -64'sd500000000;
        return (n * 64'sd67108864 + half) / 64'sd1000000000;
    endfunction

    task automatic set_taps(input logic [1:0] cs, input longint n0,
                            input longint nb [TAPS], input longint na [TAPS]);
        tap_b0[cs] = q526(n0);
        for (int j = 0; j < TAPS; j++)
        begin
            tap_b[cs][j] = q526(nb[j]);
            tap_a[cs][j] = q526(na[j]);
        end
    endtask

    function automatic longint clip48(input longint v);
        if (v > MAX48)
            return MAX48;
        if (v < MIN48)
            return MIN48;
        return v;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 64'sd32767)
            return 16'sh7FFF;
        if (v < -64'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Q23.24 times Q5.26, rounded half up back to Q23.24
    function automatic longint scale_q(input longint p, input longint c);
        logic signed [95:0] pw;
        logic signed [95:0] cw;
        logic signed [95:0] pr;
        pw = p;
        cw = c;
        pr = pw * cw + 96'sd33554432;
        pr = pr >>> 26;
        return pr[63:0];
    endfunction

    function automatic longint iir_step(input logic [1:0] cs, input longint x);
        longint xq;
        longint y;
        longint nxt;
        xq = x * 64'sd16777216;
        y = clip48(scale_q(xq, tap_b0[cs]) + dly[0]);
        for (int j = 0; j < TAPS; j++)
        begin
            nxt = (j + 1 < TAPS) ? dly[j + 1] : 64'sd0;
            dly[j] = clip48(nxt + scale_q(xq, tap_b[cs][j]) - scale_q(y, tap_a[cs][j]));
        end
        return y;
    endfunction

    function automatic void resample_frame(input logic [31:0] frame);
        longint     l;
        longint     r;
        longint     s;
        longint     q;
        longint     x;
        longint     y;
        int         up;
        bit         decim;
        bit         thru;
        bit         keep;
        bit         have_held;
        int         kept;
        logic [1:0] cs;
        pcm16_t     held;
        l = longint'($signed(frame[15:0]));
        r = longint'($signed(frame[31:16]));
        thru = 1'b0;
        cs = CS_48K;
        case (rate_cfg)
            MODE_8K:
            begin
                up = 2; decim = 1'b0; cs = CS_8K;
            end
            MODE_12K:
            begin
                up = 4; decim = 1'b1; cs = CS_12K;
            end
            MODE_16K:
            begin
                up = 1; decim = 1'b0; thru = 1'b1;
            end
            MODE_24K:
            begin
                up = 2; decim = 1'b1; cs = CS_48K;
            end
            MODE_48K:
            begin
                up = 1; decim = 1'b1; cs = CS_48K;
            end
            default:
                return;
        endcase
        if (stereo_cfg)
        begin
            s = up * (l + r);
            q = s >>> 1;
            if (s[0] && q[0])
                q = q + 1;
            x = q;
        end
        else
            x = up * l;
        x = clip16(x);
        if (thru)
        begin
            held.sample = x[15:0];
            held.last = 1'b1;
            expected_pcm.push_back(held);
            return;
        end
        if (phase > 2'd2)
            phase = 2'd0;
        kept = 0;
        have_held = 1'b0;
        for (int k = 0; k < up; k++)
        begin
            y = iir_step(cs, (k == 0) ? x : 64'sd0);
            keep = !decim || (phase == 2'd0);
            if (decim)
                phase = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
            if (keep && kept < 2)
            begin
                if (have_held)
                    expected_pcm.push_back(held);
                held.sample = clip16((y + 64'sd8388608) >>> 24);
                held.last = 1'b0;
                have_held = 1'b1;
                kept++;
            end
        end
        if (have_held)
        begin
            held.last = 1'b1;
            expected_pcm.push_back(held);
        end
    endfunction

    // monitor: config, accepted frames, output items
    always @(posedge clk)
    begin
        in_taken = s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_RATE_MODE)
                    rate_cfg = cfg_data;
                else if (cfg_index == REG_STEREO)
                    stereo_cfg = cfg_data[0];
            end
            if (in_taken)
                resample_frame(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pcm.size() == 0)
                begin
                    $display("%0t: unexpected item: expected none, got sample %0d last %0b",
                             $time, $signed(m_axis_tdata), m_axis_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_pcm.pop_front();
                    if (m_axis_tdata !== want.sample)
                    begin
                        $display("%0t: out_sample mismatch: expected %0d, got %0d",
                                 $time, want.sample, $signed(m_axis_tdata));
                        errors++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: tlast mismatch: expected %0b, got %0b",
                                 $time, want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_frames.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_frame(input logic [15:0] l, input logic [15:0] r);
        pending_frames.push_back({r, l});
        if (rate_cfg <= MODE_48K)
            filtered_items++;
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [2:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_quiet(input int settle);
        while (pending_frames.size() != 0 || s_axis_tvalid || expected_pcm.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_idling(input int sel);
        case (sel)
            0:
            begin
                send_idle_pct = 0; recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 87; recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0; recv_stall_pct = 87;
            end
            default:
            begin
                send_idle_pct = 24; recv_stall_pct = 24;
            end
        endcase
    endtask

    function automatic logic [15:0] pick_sample(input int style, input int i);
        case (style)
            0:
                return 16'($urandom);
            1:
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            2:
                return 16'($urandom_range(511)) - 16'd256;
            default:
                // full-scale square wave drives the output into saturation
                return ((i / 4) % 2) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    initial
    begin
        int         n;
        int         style;
        int         pause_at;
        int         phase_no;
        logic [2:0] mode;
        logic [15:0] l;

        set_taps(CS_48K, 64'sd4523418,
            '{64'sd5873358, 64'sd12980855, 64'sd14531340, 64'sd14531340,
              64'sd12980855, 64'sd5873358, 64'sd4523418},
            '{-64'sd3878718598, 64'sd7748834257, -64'sd9653651700, 64'sd8007342727,
              -64'sd4379450179, 64'sd1463182112, -64'sd231720678});
        set_taps(CS_12K, 64'sd2033597,
            '{-64'sd1017101, 64'sd3673127, 64'sd1009165, 64'sd1009165,
              64'sd3673127, -64'sd1017101, 64'sd2033597},
            '{-64'sd4930414412, 64'sd11291643097, -64'sd15322037344, 64'sd13216403931,
              -64'sd7220409220, 64'sd2310550143, -64'sd334338619});
        set_taps(CS_8K, 64'sd20109186,
            '{64'sd81670121, 64'sd180401599, 64'sd259391052, 64'sd259391052,
              64'sd180401599, 64'sd81670121, 64'sd20109186},
            '{-64'sd1393651934, 64'sd2609789873, -64'sd2403541969, 64'sd2056814957,
              -64'sd1148908575, 64'sd473001414, -64'sd110359852});
        for (int j = 0; j < TAPS; j++)
            dly[j] = 64'sd0;
        phase = 2'd0;
        rate_cfg = MODE_48K;
        stereo_cfg = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults after reset: 48 kHz mono, some items keep no sample
        push_frame(16'h7FFF, 16'h8000);
        push_frame(16'h8000, 16'h7FFF);
        push_frame(16'h0000, 16'hFFFF);
        push_frame(16'h7FFF, 16'h0000);
        wait_quiet(SETTLE_CYCLES);

        // 16 kHz pass-through and stereo rounding to even
        write_reg(REG_STEREO, 3'd1);
        write_reg(REG_RATE_MODE, MODE_16K);
        push_frame(16'h7FFF, 16'h7FFF);
        push_frame(16'h8000, 16'h8000);
        push_frame(16'h7FFF, 16'h8000);
        push_frame(16'h0001, 16'h0000);
        push_frame(16'hFFFF, 16'h0000);
        push_frame(16'h0003, 16'h0000);
        wait_quiet(SETTLE_CYCLES);

        // 8 kHz mono, x2 gain saturates
        write_reg(REG_STEREO, 3'd0);
        write_reg(REG_RATE_MODE, MODE_8K);
        push_frame(16'h7FFF, 16'h1234);
        push_frame(16'h8000, 16'h0000);
        push_frame(16'h4000, 16'hFFFF);
        wait_quiet(SETTLE_CYCLES);

        // 12 kHz stereo, rate change keeps filter state and phase
        write_reg(REG_STEREO, 3'd1);
        write_reg(REG_RATE_MODE, MODE_12K);
        push_frame(16'h7FFF, 16'h7FFF);
        push_frame(16'h8000, 16'h8000);
        push_frame(16'd1000, -16'sd999);
        wait_quiet(SETTLE_CYCLES);

        write_reg(REG_STEREO, 3'd0);
        write_reg(REG_RATE_MODE, MODE_24K);
        push_frame(16'h8000, 16'h7FFF);
        push_frame(16'h7FFF, 16'h8000);
        push_frame(16'h0000, 16'h0000);
        wait_quiet(SETTLE_CYCLES);

        // unused rate codes: frames ignored; spare register index ignored
        write_reg(REG_RATE_MODE, 3'd7);
        write_reg(REG_SPARE, 3'd5);
        push_frame(16'h7FFF, 16'h7FFF);
        push_frame(16'h8000, 16'h1111);
        push_frame(16'h5555, 16'hAAAA);
        wait_quiet(SETTLE_CYCLES);

        phase_no = 0;
        while (filtered_items < ITEM_TARGET)
        begin
            set_idling(phase_no % 4);
            if ($urandom_range(11) == 0)
                mode = MODE_48K + 3'($urandom_range(1, 3));
            else
                mode = 3'($urandom_range(MODE_48K));
            write_reg(REG_RATE_MODE, mode);
            write_reg(REG_STEREO, 3'($urandom));
            n = $urandom_range(30, 80);
            style = $urandom_range(3);
            pause_at = (phase_no % 3 == 1) ? n / 2 : -1;
            for (int i = 0; i < n; i++)
            begin
                if (i == pause_at)
                    wait_quiet(0);
                l = pick_sample(style, i);
                push_frame(l, (style == 3) ? l : pick_sample($urandom_range(2), i));
            end
            wait_quiet(SETTLE_CYCLES);
            phase_no++;
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
